// ===== rtl/tpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and codes of the two-class priority queue: operation and
// status codes, field widths and the control bundle sent to every cell.
// ----------------------------------------------------------------------------
package tpq_pkg;

   localparam int AGE_BITS     = 8;
   localparam int ID_PORT_BITS = 16;
   localparam int COUNT_BITS   = 5;

   localparam logic [1:0] OP_INSERT   = 2'd0;
   localparam logic [1:0] OP_SERVE    = 2'd1;
   localparam logic [1:0] OP_WITHDRAW = 2'd2;
   localparam logic [1:0] OP_QUERY    = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DUP     = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   localparam logic [AGE_BITS-1:0] THRESHOLD_RESET = 8'd60;

   // control broadcast to the row of cells
   typedef struct packed {
      logic                capture;   // latch id compare result
      logic                ins;       // insert takes effect
      logic                rem;       // removal takes effect
      logic                new_pref;  // class of the entry being inserted
      logic [AGE_BITS-1:0] age;       // age of the entry being inserted
   } ctrl_type;

endpackage

// ===== rtl/tpq_cell.sv =====
// ----------------------------------------------------------------------------
// tpq_cell
// One slot of the queue. Holds an id, an age and a class bit, compares its
// id against the incoming id, and on insert or removal takes its new value
// from the left neighbor, the right neighbor or the inserted entry.
// ----------------------------------------------------------------------------
module tpq_cell #(
   parameter int KEY_BITS = 16
) (
   input  logic                         clock,
   input  tpq_pkg::ctrl_type            ctrl,
   input  logic [KEY_BITS-1:0]          cmp_key,
   input  logic [KEY_BITS-1:0]          new_key,
   input  logic                         occ,
   input  logic                         after,
   input  logic                         left_occ,
   input  logic                         left_pref,
   input  logic [KEY_BITS-1:0]          left_key,
   input  logic [tpq_pkg::AGE_BITS-1:0] left_age,
   input  logic [KEY_BITS-1:0]          right_key,
   input  logic [tpq_pkg::AGE_BITS-1:0] right_age,
   input  logic                         right_pref,
   output logic [KEY_BITS-1:0]          key,
   output logic [tpq_pkg::AGE_BITS-1:0] age,
   output logic                         pref,
   output logic                         hit
);
   import tpq_pkg::*;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [AGE_BITS-1:0] age_ff, age_in;
   logic                pref_ff, pref_in;
   logic                hit_ff;
   logic                at_here;
   logic                shift_here;

   // preferential entries form a prefix, so the insert point and the shift
   // region are found from the left neighbor and the cell's own occupancy and class
   always_comb begin
      if (ctrl.new_pref) begin
         at_here    = left_occ & left_pref & ~(occ & pref_ff);
         shift_here = left_occ & ~left_pref;
      end else begin
         at_here    = left_occ & ~occ;
         shift_here = 1'b0;
      end
   end

   always_comb begin
      key_in  = key_ff;
      age_in  = age_ff;
      pref_in = pref_ff;
      priority if (ctrl.ins && at_here) begin
         key_in  = new_key;
         age_in  = ctrl.age;
         pref_in = ctrl.new_pref;
      end else if (ctrl.ins && shift_here) begin
         key_in  = left_key;
         age_in  = left_age;
         pref_in = left_pref;
      end else if (ctrl.rem && after) begin
         key_in  = right_key;
         age_in  = right_age;
         pref_in = right_pref;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      age_ff  <= age_in;
      pref_ff <= pref_in;
      if (ctrl.capture) begin
         hit_ff <= occ & (key_ff == cmp_key);
      end
   end

   assign key  = key_ff;
   assign age  = age_ff;
   assign pref = pref_ff;
   assign hit  = hit_ff;

endmodule

// ===== rtl/two_class_priority_queue.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_queue
// Bounded queue of (id, age) entries held in a row of cells, preferential
// entries ahead of ordinary ones, with serve, withdraw and query by id.
// ----------------------------------------------------------------------------
// Each operation runs in order: at the transfer every cell compares its id
// with the incoming one in parallel and registers the hit, and once the
// result register is free the row shifts by one place locally (insert or
// removal) and the result is registered. The block takes a new operation only
// after that shift, so it never starts an operation before the last is done;
// a stalled result holds the queue until it is taken. Ids are compared on
// their low ID_BITS bits. Slots need no clearing after reset.
module two_class_priority_queue #(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_op,
   input  logic [tpq_pkg::ID_PORT_BITS-1:0] req_person_id,
   input  logic [tpq_pkg::AGE_BITS-1:0]     req_age,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_ok,
   output logic [1:0]                       rsp_status,
   output logic [tpq_pkg::ID_PORT_BITS-1:0] rsp_served_id,
   output logic [tpq_pkg::AGE_BITS-1:0]     rsp_found_age,
   output logic [tpq_pkg::COUNT_BITS-1:0]   rsp_count,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [2:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import tpq_pkg::*;

   localparam int KEY_BITS  = (ID_BITS < ID_PORT_BITS) ? ID_BITS : ID_PORT_BITS;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int LEVELS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

   // configuration
   logic [AGE_BITS-1:0] thresh_ff;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(thresh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESHOLD_RESET;
      end else if (csr_write) begin
         thresh_ff <= csr_pwdata[AGE_BITS-1:0];
      end
   end

   // operation control
   logic                busy_ff;
   logic [1:0]          op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [AGE_BITS-1:0] age_ff;
   logic                pref_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                accept;
   logic                apply;

   assign req_stall = busy_ff;
   assign accept    = req_valid & ~busy_ff;
   assign apply     = busy_ff & (~rsp_valid | ~rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (apply) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_op;
         key_ff  <= req_person_id[KEY_BITS-1:0];
         age_ff  <= req_age;
         pref_ff <= (req_age >= thresh_ff);
      end
   end

   // row of cells
   logic [KEY_BITS-1:0] cell_key [DEPTH];
   logic [AGE_BITS-1:0] cell_age [DEPTH];
   logic [DEPTH-1:0]    cell_pref;
   logic [DEPTH-1:0]    cell_hit;
   logic [DEPTH-1:0]    occ;
   logic [DEPTH-1:0]    after;
   logic [DEPTH-1:0]    hit_prefix;
   logic [DEPTH-1:0]    scan [LEVELS+1];
   ctrl_type            ctrl;
   logic                any_hit;
   logic                full;
   logic                empty;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         occ[i] = (count_ff > CNT_BITS'(i));
      end
   end

   // parallel prefix or of the one-hot hit vector marks the removed slot and
   // every slot to its right
   always_comb begin
      scan[0] = cell_hit;
      for (int l = 0; l < LEVELS; l++) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (i >= (1 << l)) begin
               scan[l+1][i] = scan[l][i] | scan[l][i - (1 << l)];
            end else begin
               scan[l+1][i] = scan[l][i];
            end
         end
      end
      hit_prefix = scan[LEVELS];
   end

   assign any_hit = |cell_hit;
   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign after   = (op_ff == OP_SERVE) ? {DEPTH{1'b1}} : hit_prefix;

   always_comb begin
      ctrl.capture  = accept;
      ctrl.ins      = apply & (op_ff == OP_INSERT) & ~any_hit & ~full;
      ctrl.rem      = apply & (((op_ff == OP_SERVE) & ~empty) |
                               ((op_ff == OP_WITHDRAW) & any_hit));
      ctrl.new_pref = pref_ff;
      ctrl.age      = age_ff;
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic                left_occ;
      logic                left_pref;
      logic [KEY_BITS-1:0] left_key;
      logic [AGE_BITS-1:0] left_age;
      logic [KEY_BITS-1:0] right_key;
      logic [AGE_BITS-1:0] right_age;
      logic                right_pref;

      if (g == 0) begin : g_head
         assign left_occ  = 1'b1;
         assign left_pref = 1'b1;
         assign left_key  = '0;
         assign left_age  = '0;
      end else begin : g_body
         assign left_occ  = occ[g-1];
         assign left_pref = cell_pref[g-1];
         assign left_key  = cell_key[g-1];
         assign left_age  = cell_age[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign right_key  = '0;
         assign right_age  = '0;
         assign right_pref = 1'b0;
      end else begin : g_inner
         assign right_key  = cell_key[g+1];
         assign right_age  = cell_age[g+1];
         assign right_pref = cell_pref[g+1];
      end

      tpq_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cmp_key    (req_person_id[KEY_BITS-1:0]),
         .new_key    (key_ff),
         .occ        (occ[g]),
         .after      (after[g]),
         .left_occ   (left_occ),
         .left_pref  (left_pref),
         .left_key   (left_key),
         .left_age   (left_age),
         .right_key  (right_key),
         .right_age  (right_age),
         .right_pref (right_pref),
         .key        (cell_key[g]),
         .age        (cell_age[g]),
         .pref       (cell_pref[g]),
         .hit        (cell_hit[g])
      );
   end

   // result
   logic [AGE_BITS-1:0]     hit_age;
   logic [1:0]              status_in;
   logic [ID_PORT_BITS-1:0] served_in;
   logic [AGE_BITS-1:0]     found_in;

   always_comb begin
      hit_age = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_age = hit_age | (cell_hit[i] ? cell_age[i] : '0);
      end
   end

   always_comb begin
      status_in = ST_OK;
      served_in = '0;
      found_in  = '0;
      unique case (op_ff)
         OP_INSERT: begin
            if (any_hit) begin
               status_in = ST_DUP;
            end else if (full) begin
               status_in = ST_FULL;
            end
         end
         OP_SERVE: begin
            if (empty) begin
               status_in = ST_MISSING;
            end else begin
               served_in = ID_PORT_BITS'(cell_key[0]);
            end
         end
         OP_WITHDRAW: begin
            if (!any_hit) begin
               status_in = ST_MISSING;
            end
         end
         OP_QUERY: begin
            if (any_hit) begin
               found_in = hit_age;
            end else begin
               status_in = ST_MISSING;
            end
         end
         default: begin
            status_in = ST_MISSING;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.rem) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   logic                    rsp_valid_ff;
   logic                    rsp_ok_ff;
   logic [1:0]              rsp_status_ff;
   logic [ID_PORT_BITS-1:0] rsp_served_ff;
   logic [AGE_BITS-1:0]     rsp_found_ff;
   logic [COUNT_BITS-1:0]   rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (apply) begin
         rsp_ok_ff     <= (status_in == ST_OK);
         rsp_status_ff <= status_in;
         rsp_served_ff <= served_in;
         rsp_found_ff  <= found_in;
         rsp_count_ff  <= COUNT_BITS'(count_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_served_id = rsp_served_ff;
   assign rsp_found_age = rsp_found_ff;
   assign rsp_count     = rsp_count_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond depth");

   a_unique_hit: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot0(cell_hit))
      else $error("id matched in more than one slot");

   a_count_held: assert property (@(posedge clock) disable iff (reset)
      !apply |=> $stable(count_ff))
      else $error("count changed without an operation");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ok_ff == (rsp_status_ff == ST_OK)))
      else $error("ok flag disagrees with status");

   a_empty_serve: assert property (@(posedge clock) disable iff (reset)
      (apply && op_ff == OP_SERVE && empty) |=> (rsp_served_ff == '0))
      else $error("serve on empty queue returned an id");

endmodule

// ===== verif/tpq_queue_checker.sv =====
// ----------------------------------------------------------------------------
// tpq_queue_checker
// Watches both channels and the register port of the two-class priority
// queue, keeps its own copy of the queue contents and threshold, predicts
// the reply to every accepted operation and compares replies in order.
// ----------------------------------------------------------------------------
module tpq_queue_checker
   import tpq_pkg::*;
#(
   parameter int         DEPTH          = 16,
   parameter int         ID_BITS        = 16,
   parameter logic [2:0] THRESHOLD_ADDR = 3'd0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [1:0]              req_op,
   input  logic [ID_PORT_BITS-1:0] req_person_id,
   input  logic [AGE_BITS-1:0]     req_age,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_ok,
   input  logic [1:0]              rsp_status,
   input  logic [ID_PORT_BITS-1:0] rsp_served_id,
   input  logic [AGE_BITS-1:0]     rsp_found_age,
   input  logic [COUNT_BITS-1:0]   rsp_count,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   input  logic                    csr_pready,
   output int                      mismatch_count,
   output int                      results_pending
);

   localparam logic [ID_PORT_BITS-1:0] ID_MASK = ID_PORT_BITS'((64'd1 << ID_BITS) - 1);

   typedef struct packed {
      logic [ID_PORT_BITS-1:0] id;
      logic [AGE_BITS-1:0]     age;
      logic                    pref;
   } slot_entry_type;

   typedef struct packed {
      logic                    ok;
      logic [1:0]              status;
      logic [ID_PORT_BITS-1:0] served_id;
      logic [AGE_BITS-1:0]     found_age;
      logic [COUNT_BITS-1:0]   count;
   } queue_reply_type;

   slot_entry_type      queue_slots[$];
   queue_reply_type     expected_replies[$];
   logic [AGE_BITS-1:0] pref_threshold;
   int                  failures;

   initial begin
      mismatch_count  = 0;
      results_pending = 0;
      failures        = 0;
      pref_threshold  = THRESHOLD_RESET;
   end

   // applies one operation to the local queue copy and returns its reply
   function automatic queue_reply_type apply_queue_op(input logic [1:0] op,
                                                      input logic [ID_PORT_BITS-1:0] person_id,
                                                      input logic [AGE_BITS-1:0] age);
      queue_reply_type         reply;
      slot_entry_type          entry;
      logic [ID_PORT_BITS-1:0] key;
      int                      pos;
      int                      at;
      key          = person_id & ID_MASK;
      reply        = '0;
      reply.status = ST_OK;
      pos          = -1;
      foreach (queue_slots[i]) begin
         if (pos < 0 && queue_slots[i].id == key) pos = i;
      end
      case (op)
         OP_INSERT: begin
            if (pos >= 0) begin
               reply.status = ST_DUP;
            end else if (queue_slots.size() >= DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               entry.id   = key;
               entry.age  = age;
               entry.pref = (age >= pref_threshold);
               at = queue_slots.size();
               // preferential entries go behind the last preferential one
               if (entry.pref) begin
                  at = 0;
                  while (at < queue_slots.size() && queue_slots[at].pref) at++;
               end
               queue_slots.insert(at, entry);
            end
         end
         OP_SERVE: begin
            if (queue_slots.size() == 0) begin
               reply.status = ST_MISSING;
            end else begin
               reply.served_id = queue_slots[0].id;
               queue_slots.delete(0);
            end
         end
         OP_WITHDRAW: begin
            if (pos < 0) reply.status = ST_MISSING;
            else queue_slots.delete(pos);
         end
         default: begin
            if (pos < 0) reply.status = ST_MISSING;
            else reply.found_age = queue_slots[pos].age;
         end
      endcase
      reply.ok    = (reply.status == ST_OK);
      reply.count = COUNT_BITS'(queue_slots.size());
      return reply;
   endfunction

   always @(posedge clock) begin
      queue_reply_type expected;
      queue_reply_type actual;
      if (reset) begin
         queue_slots.delete();
         expected_replies.delete();
         pref_threshold = THRESHOLD_RESET;
      end else begin
         // an operation taken at the same edge as a register write sees the old threshold
         if (req_valid && !req_stall) begin
            expected_replies.push_back(apply_queue_op(req_op, req_person_id, req_age));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == THRESHOLD_ADDR) begin
            pref_threshold = csr_pwdata[AGE_BITS-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            actual = {rsp_ok, rsp_status, rsp_served_id, rsp_found_age, rsp_count};
            if (expected_replies.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display({"unexpected reply: ok=%0d status=%0d served_id=%h ",
                            "found_age=%0d count=%0d"},
                           actual.ok, actual.status, actual.served_id, actual.found_age,
                           actual.count);
            end else begin
               expected = expected_replies.pop_front();
               if (actual !== expected) begin
                  failures++;
                  if (failures <= 10)
                     $display({"reply mismatch: expected ok=%0d status=%0d served_id=%h ",
                               "found_age=%0d count=%0d, got ok=%0d status=%0d served_id=%h ",
                               "found_age=%0d count=%0d"},
                              expected.ok, expected.status, expected.served_id,
                              expected.found_age, expected.count,
                              actual.ok, actual.status, actual.served_id,
                              actual.found_age, actual.count);
               end
            end
         end
      end
      mismatch_count  <= failures;
      results_pending <= expected_replies.size();
   end

endmodule

// ===== verif/tb_two_class_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_two_class_priority_queue
// Drives insert, serve, withdraw and query operations into the two-class
// priority queue under several threshold settings and idle patterns; a
// checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_two_class_priority_queue;
   import tpq_pkg::*;

   localparam logic [2:0] REG_PREF_AGE_THRESHOLD = 3'd0;
   localparam int         RUN_LIMIT              = 200000;
   localparam int         ITEMS_PER_PHASE        = 220;
   localparam int         POOL_SIZE              = 20;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_op        = OP_INSERT;
   logic [ID_PORT_BITS-1:0] req_person_id = '0;
   logic [AGE_BITS-1:0]     req_age       = '0;
   logic                    rsp_valid;
   logic                    rsp_stall     = 1'b0;
   logic                    rsp_ok;
   logic [1:0]              rsp_status;
   logic [ID_PORT_BITS-1:0] rsp_served_id;
   logic [AGE_BITS-1:0]     rsp_found_age;
   logic [COUNT_BITS-1:0]   rsp_count;
   logic                    csr_psel      = 1'b0;
   logic                    csr_penable   = 1'b0;
   logic                    csr_pwrite    = 1'b0;
   logic [2:0]              csr_paddr     = '0;
   logic [31:0]             csr_pwdata    = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   int                      mismatch_count;
   int                      results_pending;
   int                      cycle_count    = 0;
   int                      send_idle_pct  = 0;
   int                      rsp_stall_pct  = 0;
   int                      insert_pct     = 50;
   logic [AGE_BITS-1:0]     threshold_now  = THRESHOLD_RESET;
   logic [ID_PORT_BITS-1:0] id_pool[POOL_SIZE];

   two_class_priority_queue #(
      .DEPTH  (16),
      .ID_BITS(16)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_person_id(req_person_id),
      .req_age      (req_age),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_ok       (rsp_ok),
      .rsp_status   (rsp_status),
      .rsp_served_id(rsp_served_id),
      .rsp_found_age(rsp_found_age),
      .rsp_count    (rsp_count),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   tpq_queue_checker #(
      .DEPTH         (16),
      .ID_BITS       (16),
      .THRESHOLD_ADDR(REG_PREF_AGE_THRESHOLD)
   ) i_queue_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_person_id  (req_person_id),
      .req_age        (req_age),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_status     (rsp_status),
      .rsp_served_id  (rsp_served_id),
      .rsp_found_age  (rsp_found_age),
      .rsp_count      (rsp_count),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .results_pending(results_pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // one transfer on the request channel, with an optional gap before it
   task send_op(input logic [1:0] op, input logic [ID_PORT_BITS-1:0] person_id,
                input logic [AGE_BITS-1:0] age);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_person_id <= person_id;
      req_age       <= age;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait for every outstanding reply
   task drain_replies;
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   task write_threshold(input logic [AGE_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_PREF_AGE_THRESHOLD;
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      threshold_now = value;
   endtask

   // mostly ids from a small pool so that hits and duplicates are common
   function automatic logic [ID_PORT_BITS-1:0] pick_id();
      if ($urandom_range(0, 9) == 0) return ID_PORT_BITS'($urandom_range(0, 65535));
      return id_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   function automatic logic [AGE_BITS-1:0] pick_age();
      int a;
      if ($urandom_range(0, 2) == 0) begin
         a = int'(threshold_now) + int'($urandom_range(0, 2)) - 1;
         if (a < 0) a = 0;
         if (a > 255) a = 255;
         return AGE_BITS'(a);
      end
      return AGE_BITS'($urandom_range(0, 255));
   endfunction

   task send_random_op;
      logic [1:0] op;
      int         r;
      r = $urandom_range(0, 99);
      if (r < insert_pct) op = OP_INSERT;
      else if (r % 3 == 0) op = OP_SERVE;
      else if (r % 3 == 1) op = OP_WITHDRAW;
      else op = OP_QUERY;
      send_op(op, pick_id(), pick_age());
   endtask

   initial begin
      foreach (id_pool[i]) id_pool[i] = ID_PORT_BITS'($urandom_range(0, 65535));
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue cases, both classes, threshold boundary, duplicates
      send_op(OP_SERVE, 16'h0000, 8'd0);
      send_op(OP_WITHDRAW, 16'h0001, 8'd0);
      send_op(OP_QUERY, 16'h0000, 8'd0);
      send_op(OP_INSERT, 16'h0000, 8'd0);
      send_op(OP_INSERT, 16'hFFFF, 8'd255);
      send_op(OP_INSERT, 16'h1234, 8'd60);
      send_op(OP_INSERT, 16'h0000, 8'd100);
      send_op(OP_QUERY, 16'hFFFF, 8'd0);
      send_op(OP_WITHDRAW, 16'hFFFF, 8'd0);
      // last preferential entry leaves, ordinary one takes the head
      send_op(OP_SERVE, 16'h0000, 8'd0);
      // fill to capacity, then duplicate and full on a full queue
      for (int i = 0; i < 16; i++) begin
         send_op(OP_INSERT, ID_PORT_BITS'(i * 16'h1111), AGE_BITS'(i * 17));
      end
      send_op(OP_INSERT, 16'h0000, 8'd7);
      send_op(OP_INSERT, 16'h0BAD, 8'd200);
      drain_replies();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_threshold(8'd0);
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               write_threshold(8'd255);
               send_idle_pct = 60;
               rsp_stall_pct = 0;
            end
            2: begin
               write_threshold(8'd128);
               send_idle_pct = 0;
               rsp_stall_pct = 60;
            end
            3: begin
               write_threshold(AGE_BITS'($urandom_range(1, 254)));
               send_idle_pct = 37;
               rsp_stall_pct = 37;
            end
            default: begin
               write_threshold(THRESHOLD_RESET);
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // swing between filling and draining so both ends get visited
            if (n % 40 == 0) insert_pct = (insert_pct > 40) ? 25 : 60;
            if (n == ITEMS_PER_PHASE / 2) drain_replies();
            send_random_op();
         end
         drain_replies();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tpq_pkg.sv
rtl/tpq_cell.sv
rtl/two_class_priority_queue.sv
verif/tpq_queue_checker.sv
verif/tb_two_class_priority_queue.sv
